[rtl/fia_pkg.sv]
`default_nettype none
package fia_pkg;

	localparam int WINDOW_DEPTH = 64;
	localparam int TIME_W       = 48;
	localparam int PTR_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W        = TIME_W + PTR_W;
	localparam int SEC_W        = TIME_W + 1;
	localparam int DIV_CNT_W    = $clog2(SUM_W + 1);
	localparam int REG_W        = 32;
	localparam int CFG_IDX_W    = 8;
	localparam int RATE_W       = 16;
	localparam int IN_W         = ((TIME_W + 7) / 8) * 8;
	localparam int OUT_RAW_W    = TIME_W + RATE_W + CNT_W;
	localparam int OUT_W        = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic [REG_W-1:0] TPS_RESET = 32'd10000000;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_PERIOD      = 8'd1;

	typedef enum logic [3:0] {
		OP_CAPTURE,
		OP_ELAPSED,
		OP_CLASSIFY,
		OP_RING_READ,
		OP_UPDATE,
		OP_RATE,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_NO_INPUT,
		COND_NOT_TAKEN,
		COND_DIV_MORE,
		COND_OUT_BUSY
	} cond_t;

	localparam int PROG_LEN = 9;
	localparam int PC_W     = $clog2(PROG_LEN);

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	localparam logic [PC_W-1:0] STEP_FETCH = PC_W'(0);
	localparam logic [PC_W-1:0] STEP_DIV   = PC_W'(6);
	localparam logic [PC_W-1:0] STEP_EMIT  = PC_W'(8);

	localparam uword_t MICROCODE [PROG_LEN] = '{
		'{OP_CAPTURE,   COND_NO_INPUT,  STEP_FETCH},
		'{OP_ELAPSED,   COND_NEXT,      STEP_FETCH},
		'{OP_CLASSIFY,  COND_NEXT,      STEP_FETCH},
		'{OP_RING_READ, COND_NOT_TAKEN, STEP_EMIT},
		'{OP_UPDATE,    COND_NEXT,      STEP_FETCH},
		'{OP_RATE,      COND_NEXT,      STEP_FETCH},
		'{OP_DIV_STEP,  COND_DIV_MORE,  STEP_DIV},
		'{OP_DIV_DONE,  COND_NEXT,      STEP_FETCH},
		'{OP_EMIT,      COND_OUT_BUSY,  STEP_EMIT}
	};

endpackage
`default_nettype wire

[rtl/frame_interval_averager_top.sv]
// frame interval averager
// s_* takes one word per frame event: a 48-bit free-running tick counter
// reading. m_* returns one word per input: frame_taken in m_tuser, and the
// average interval, latched frame rate and window fill in m_tdata.
// cfg_* writes ticks_per_second (index 0) or lock_period (index 1); other
// indexes are ignored. cfg_ready is always high; write only while idle.
// a small microprogram runs each taken reading through capture, classify,
// ring update and a one-bit-per-cycle restoring divider for the window
// average; readings that are not taken skip the ring update and divider.
// one reading is in flight at a time, so a new word is accepted only
// after the last one has reached the output word register.
// the output word sits in a register: the next reading is accepted while it
// waits, and the sequencer only holds at its final step if the previous
// word is still not taken. reset clears all control and statistics; the
// interval ring needs no clearing since only written entries are used.
`default_nettype none
module frame_interval_averager_top
	import fia_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_W-1:0]      s_tdata,   // timestamp
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [OUT_W-1:0]          m_tdata,   // average_interval, frame_rate, samples_held
	output logic                      m_tuser,   // frame_taken
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data
);

	logic [PC_W-1:0]      pc_q, pc_d;
	uword_t               ctrl;
	logic                 jump;

	logic [REG_W-1:0]     tps_q, lock_q;
	logic                 started_q, taken_q, enter_q;
	logic [TIME_W-1:0]    now_q, last_q, elapsed_q, avg_q, ring_rd_q;
	logic [PTR_W-1:0]     wp_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SEC_W-1:0]     sacc_q;
	logic [RATE_W-1:0]    fps_q, rate_q;
	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [TIME_W-1:0]    ring [WINDOW_DEPTH];

	logic                 out_busy;
	logic [TIME_W-1:0]    diff;
	logic [SEC_W:0]       sacc_sum;
	logic [CNT_W:0]       rem_sh;
	logic                 rem_ge;
	logic                 full;

	assign ctrl      = MICROCODE[pc_q];
	assign cfg_ready = 1'b1;
	assign s_tready  = (ctrl.op == OP_CAPTURE);
	assign out_busy  = m_tvalid && !m_tready;
	assign full      = (count_q == CNT_W'(WINDOW_DEPTH));

	always_comb begin
		unique case (ctrl.cond)
			COND_NEXT:      jump = 1'b0;
			COND_NO_INPUT:  jump = !s_tvalid;
			COND_NOT_TAKEN: jump = !taken_q;
			COND_DIV_MORE:  jump = (div_cnt_q != DIV_CNT_W'(1));
			COND_OUT_BUSY:  jump = out_busy;
			default:        jump = 1'b0;
		endcase
		if (jump) begin
			pc_d = ctrl.target;
		end else if (pc_q == PC_W'(PROG_LEN - 1)) begin
			pc_d = STEP_FETCH;
		end else begin
			pc_d = pc_q + PC_W'(1);
		end
	end

	always_comb begin
		diff     = (elapsed_q > avg_q) ? elapsed_q - avg_q : avg_q - elapsed_q;
		sacc_sum = {1'b0, sacc_q} + (SEC_W + 1)'(elapsed_q);
		rem_sh   = {rem_q, quo_q[SUM_W-1]};
		rem_ge   = (rem_sh >= {1'b0, count_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q  <= TPS_RESET;
			lock_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_TICKS_PER_SECOND) begin
				tps_q <= cfg_data;
			end else if (cfg_index == REG_LOCK_PERIOD) begin
				lock_q <= cfg_data;
			end
		end
	end

	// interval ring
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_RING_READ) begin
			ring_rd_q <= ring[wp_q];
		end
		if (ctrl.op == OP_UPDATE && enter_q) begin
			ring[wp_q] <= elapsed_q;
		end
	end

	// statistics datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			taken_q   <= 1'b0;
			enter_q   <= 1'b0;
			now_q     <= '0;
			elapsed_q <= '0;
			last_q    <= '0;
			wp_q      <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			avg_q     <= '0;
			fps_q     <= '0;
			sacc_q    <= '0;
			rate_q    <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (ctrl.op)
				OP_CAPTURE: begin
					if (s_tvalid) begin
						now_q <= s_tdata[TIME_W-1:0];
					end
				end
				OP_ELAPSED: begin
					elapsed_q <= now_q - last_q;
				end
				OP_CLASSIFY: begin
					if (!started_q) begin
						started_q <= 1'b1;
						last_q    <= now_q;
						taken_q   <= 1'b0;
					end else begin
						taken_q <= !((lock_q != '0) && (64'(elapsed_q) < 64'(lock_q)));
					end
					enter_q <= (64'(diff) < 64'(tps_q));
				end
				OP_RING_READ: begin
				end
				OP_UPDATE: begin
					last_q <= now_q;
					if (enter_q) begin
						wp_q    <= wp_q + PTR_W'(1);
						sum_q   <= sum_q + SUM_W'(elapsed_q) - (full ? SUM_W'(ring_rd_q) : '0);
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					if (fps_q != '1) begin
						fps_q <= fps_q + RATE_W'(1);
					end
					sacc_q <= sacc_sum[SEC_W] ? '1 : sacc_sum[SEC_W-1:0];
				end
				OP_RATE: begin
					if (sacc_q > SEC_W'(tps_q)) begin
						rate_q <= fps_q;
						fps_q  <= '0;
						sacc_q <= '0;
					end
					quo_q     <= sum_q;
					rem_q     <= '0;
					div_cnt_q <= DIV_CNT_W'(SUM_W);
				end
				OP_DIV_STEP: begin
					rem_q     <= rem_ge ? CNT_W'(rem_sh - {1'b0, count_q}) : rem_sh[CNT_W-1:0];
					quo_q     <= {quo_q[SUM_W-2:0], rem_ge};
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
				end
				OP_DIV_DONE: begin
					avg_q <= (count_q == '0) ? '0 : quo_q[TIME_W-1:0];
				end
				OP_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ctrl.op == OP_EMIT && !out_busy) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EMIT && !out_busy) begin
			m_tuser <= taken_q;
			m_tdata <= OUT_W'({count_q, rate_q, avg_q});
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_DEPTH))
		else $error("window count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sum_q == '0))
		else $error("empty window with nonzero sum");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted while one is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_DIV_STEP) |-> (div_cnt_q != '0))
		else $error("divider ran past its last bit");

endmodule
`default_nettype wire
